// ===== rtl/djss_pkg.sv =====
// djss_pkg: shared constants for the deadline job slot scheduler
// no dependencies; imported by the top level

package djss_pkg;

    localparam int MAX_JOBS_DEF = 64;
    localparam int FIELD_W      = 16;
    localparam int COUNT_W      = 7;
    localparam int PROFIT_W     = 22;

    localparam logic [COUNT_W-1:0]  COUNT_SAT  = {COUNT_W{1'b1}};
    localparam logic [PROFIT_W-1:0] PROFIT_SAT = {PROFIT_W{1'b1}};

endpackage

// ===== rtl/djss_ram.sv =====
// djss_ram: generic single write port, single read port ram with registered read
// no dependencies

module djss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/deadline_job_slot_scheduler.sv =====
// deadline_job_slot_scheduler: greedy job sequencing with deadlines, on djss_pkg and djss_ram
// a job beat stalls the input through the sorted insert, which reads and compares each stored job
//   it moves down and then writes the new one; a dropped beat, unless last, does not stall it
// the last beat adds slot init, then per job a read, a find walk and a compress walk over the
//   slot entries, and a close of the set that posts the result
// reset clears control and counters; stores are undefined until written

module deadline_job_slot_scheduler
    import djss_pkg::*;
#(
    parameter int MAX_JOBS = MAX_JOBS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [FIELD_W-1:0]  job_deadline,
    input  logic [FIELD_W-1:0]  job_profit,
    input  logic                last_job,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [COUNT_W-1:0]  scheduled_count,
    output logic [PROFIT_W-1:0] total_profit,
    output logic                set_overflow
);

    localparam int IW = $clog2(MAX_JOBS);
    localparam int SW = $clog2(MAX_JOBS + 1);
    localparam int EW = SW + FIELD_W;
    localparam logic [SW-1:0] MAX_S = SW'(MAX_JOBS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT,
        S_INIT,
        S_JOB_RD,
        S_JOB_GET,
        S_FIND_RD,
        S_FIND_CMP,
        S_CMP_RD,
        S_CMP_CHK,
        S_APPLY,
        S_FINISH
    } state_t;

    state_t              state_reg;
    logic [SW-1:0]       loaded_reg;
    logic                overflow_reg;
    logic [SW-1:0]       pos_reg;
    logic [SW-1:0]       new_dl_reg;
    logic [FIELD_W-1:0]  new_pr_reg;
    logic                new_last_reg;
    logic [SW-1:0]       init_reg;
    logic [SW-1:0]       job_reg;
    logic [FIELD_W-1:0]  cur_pr_reg;
    logic [SW-1:0]       walk_reg;
    logic [SW-1:0]       root_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [PROFIT_W-1:0] profit_reg;
    logic                out_valid_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic [PROFIT_W-1:0] out_profit_reg;
    logic                out_ovf_reg;

    logic                st_we;
    logic [IW-1:0]       st_waddr;
    logic [EW-1:0]       st_wdata;
    logic [IW-1:0]       st_raddr;
    logic [EW-1:0]       st_rdata;
    logic                lk_we;
    logic [SW-1:0]       lk_waddr;
    logic [SW-1:0]       lk_wdata;
    logic [SW-1:0]       lk_rdata;

    logic [SW-1:0]       rd_dl;
    logic [FIELD_W-1:0]  rd_pr;
    logic                new_first;
    logic [SW-1:0]       pos_m1;
    logic [SW-1:0]       dl_clamped;
    logic [PROFIT_W:0]   profit_sum;
    logic                in_beat;
    logic                out_free;

    assign rd_dl  = st_rdata[EW-1:FIELD_W];
    assign rd_pr  = st_rdata[FIELD_W-1:0];
    assign pos_m1 = pos_reg - SW'(1);

    // higher profit first, ties go to the larger deadline
    assign new_first = (new_pr_reg != rd_pr) ? (new_pr_reg > rd_pr) : (new_dl_reg > rd_dl);

    assign dl_clamped = (job_deadline > FIELD_W'(MAX_JOBS)) ? MAX_S : job_deadline[SW-1:0];
    assign profit_sum = {1'b0, profit_reg} + (PROFIT_W + 1)'(cur_pr_reg);

    assign in_stall = (state_reg != S_IDLE);
    assign in_beat  = in_valid && !in_stall;
    assign out_free = !(out_valid_reg && out_stall);

    assign out_valid       = out_valid_reg;
    assign scheduled_count = out_count_reg;
    assign total_profit    = out_profit_reg;
    assign set_overflow    = out_ovf_reg;

    djss_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_JOBS)
    ) u_job_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    djss_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_JOBS + 1)
    ) u_slot_link (
        .clk   (clk),
        .we    (lk_we),
        .waddr (lk_waddr),
        .wdata (lk_wdata),
        .raddr (walk_reg),
        .rdata (lk_rdata)
    );

    always_comb
    begin
        st_we    = 1'b0;
        st_waddr = pos_reg[IW-1:0];
        st_wdata = {new_dl_reg, new_pr_reg};
        st_raddr = (state_reg == S_JOB_RD) ? job_reg[IW-1:0] : pos_m1[IW-1:0];
        lk_we    = 1'b0;
        lk_waddr = walk_reg;
        lk_wdata = root_reg;
        case (state_reg)
            S_INS_CMP:
            begin
                // shift the stored job one place down
                if (new_first)
                begin
                    st_we    = 1'b1;
                    st_wdata = st_rdata;
                end
            end
            S_INS_PUT:
            begin
                st_we = 1'b1;
            end
            S_INIT:
            begin
                lk_we    = 1'b1;
                lk_waddr = init_reg;
                lk_wdata = init_reg;
            end
            S_CMP_CHK:
            begin
                lk_we = (lk_rdata != root_reg);
            end
            S_APPLY:
            begin
                lk_we    = (root_reg != '0);
                lk_waddr = root_reg;
                lk_wdata = root_reg - SW'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            loaded_reg     <= '0;
            overflow_reg   <= 1'b0;
            pos_reg        <= '0;
            new_dl_reg     <= '0;
            new_pr_reg     <= '0;
            new_last_reg   <= 1'b0;
            init_reg       <= '0;
            job_reg        <= '0;
            cur_pr_reg     <= '0;
            walk_reg       <= '0;
            root_reg       <= '0;
            count_reg      <= '0;
            profit_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_count_reg  <= '0;
            out_profit_reg <= '0;
            out_ovf_reg    <= 1'b0;
        end
        else
        begin
            // the finish state posts its own beat over a taken one
            if (out_valid_reg && !out_stall && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_beat)
                    begin
                        new_dl_reg   <= dl_clamped;
                        new_pr_reg   <= job_profit;
                        new_last_reg <= last_job;
                        pos_reg      <= loaded_reg;
                        init_reg     <= '0;
                        if (loaded_reg != MAX_S)
                        begin
                            state_reg <= (loaded_reg == '0) ? S_INS_PUT : S_INS_RD;
                        end
                        else
                        begin
                            // store full: beat is dropped
                            overflow_reg <= 1'b1;
                            state_reg    <= last_job ? S_INIT : S_IDLE;
                        end
                    end
                end
                S_INS_RD:
                begin
                    state_reg <= S_INS_CMP;
                end
                S_INS_CMP:
                begin
                    if (new_first)
                    begin
                        pos_reg   <= pos_m1;
                        state_reg <= (pos_m1 == '0) ? S_INS_PUT : S_INS_RD;
                    end
                    else
                    begin
                        state_reg <= S_INS_PUT;
                    end
                end
                S_INS_PUT:
                begin
                    loaded_reg <= loaded_reg + SW'(1);
                    state_reg  <= new_last_reg ? S_INIT : S_IDLE;
                end
                S_INIT:
                begin
                    init_reg <= init_reg + SW'(1);
                    if (init_reg == MAX_S)
                    begin
                        job_reg    <= '0;
                        count_reg  <= '0;
                        profit_reg <= '0;
                        state_reg  <= S_JOB_RD;
                    end
                end
                S_JOB_RD:
                begin
                    state_reg <= (job_reg == loaded_reg) ? S_FINISH : S_JOB_GET;
                end
                S_JOB_GET:
                begin
                    cur_pr_reg <= rd_pr;
                    walk_reg   <= rd_dl;
                    pos_reg    <= rd_dl;
                    state_reg  <= S_FIND_RD;
                end
                S_FIND_RD:
                begin
                    state_reg <= S_FIND_CMP;
                end
                S_FIND_CMP:
                begin
                    if (lk_rdata == walk_reg)
                    begin
                        // root found, walk again from the deadline to compress
                        root_reg  <= walk_reg;
                        walk_reg  <= pos_reg;
                        state_reg <= S_CMP_RD;
                    end
                    else
                    begin
                        walk_reg  <= lk_rdata;
                        state_reg <= S_FIND_RD;
                    end
                end
                S_CMP_RD:
                begin
                    state_reg <= S_CMP_CHK;
                end
                S_CMP_CHK:
                begin
                    if (lk_rdata == root_reg)
                    begin
                        state_reg <= S_APPLY;
                    end
                    else
                    begin
                        walk_reg  <= lk_rdata;
                        state_reg <= S_CMP_RD;
                    end
                end
                S_APPLY:
                begin
                    if (root_reg != '0)
                    begin
                        if (count_reg != COUNT_SAT)
                        begin
                            count_reg <= count_reg + COUNT_W'(1);
                        end
                        profit_reg <= profit_sum[PROFIT_W] ? PROFIT_SAT
                                                           : profit_sum[PROFIT_W-1:0];
                    end
                    job_reg   <= job_reg + SW'(1);
                    state_reg <= S_JOB_RD;
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_count_reg  <= count_reg;
                        out_profit_reg <= profit_reg;
                        out_ovf_reg    <= overflow_reg;
                        loaded_reg     <= '0;
                        overflow_reg   <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== test/testbench.sv =====
// testbench for deadline_job_slot_scheduler: random and directed job sets,
// results checked against a greedy job sequencing predictor
// depends on djss_pkg and the scheduler rtl

`timescale 1ns / 1ps

module testbench
    import djss_pkg::*;
();

    localparam int JOBS = MAX_JOBS_DEF;
    // longest quiet spell allowed before the watchdog ends the run
    localparam int HANG_LIMIT = 200000;
    localparam int RANDOM_JOBS = 750;
    localparam int CALM_FROM = 650;

    typedef struct packed {
        logic [FIELD_W-1:0] deadline;
        logic [FIELD_W-1:0] profit;
        logic               last;
        logic               calm;
    } job_beat_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  count;
        logic [PROFIT_W-1:0] profit;
        logic                overflow;
    } set_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [FIELD_W-1:0]  job_deadline = '0;
    logic [FIELD_W-1:0]  job_profit = '0;
    logic                last_job = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [COUNT_W-1:0]  scheduled_count;
    logic [PROFIT_W-1:0] total_profit;
    logic                set_overflow;

    job_beat_t   job_queue[$];
    set_result_t awaited_results[$];

    // predictor copy of the job store
    int held_dl[JOBS];
    int held_pr[JOBS];
    int held_jobs = 0;
    logic held_ovf = 1'b0;

    int   mismatches = 0;
    int   quiet_cycles = 0;
    logic in_took = 1'b0;
    logic calm_now = 1'b0;
    logic idle_on = 1'b1;
    logic [6:0] stretch_cnt = '0;
    int   gap_left = 0;
    int   stall_left = 0;

    deadline_job_slot_scheduler #(
        .MAX_JOBS(JOBS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .job_deadline(job_deadline),
        .job_profit(job_profit),
        .last_job(last_job),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .scheduled_count(scheduled_count),
        .total_profit(total_profit),
        .set_overflow(set_overflow)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // higher profit first, ties go to the larger deadline
    function automatic bit ranks_above(input int a, input int b);
        if (held_pr[a] != held_pr[b])
            return held_pr[a] > held_pr[b];
        return held_dl[a] > held_dl[b];
    endfunction

    task automatic take_job(input logic [FIELD_W-1:0] dl, input logic [FIELD_W-1:0] pr,
                            input logic last);
        int i;
        int j;
        int s;
        int root;
        int nxt;
        int unsigned cnt;
        int unsigned sum;
        int rank[JOBS];
        int link[JOBS+1];
        set_result_t res;
        if (held_jobs < JOBS)
        begin
            held_dl[held_jobs] = (dl > JOBS) ? JOBS : int'(dl);
            held_pr[held_jobs] = int'(pr);
            held_jobs++;
        end
        else
            held_ovf = 1'b1;
        if (last)
        begin
            for (i = 0; i < held_jobs; i++)
            begin
                j = i;
                while (j > 0 && ranks_above(i, rank[j-1]))
                begin
                    rank[j] = rank[j-1];
                    j--;
                end
                rank[j] = i;
            end
            for (i = 0; i <= JOBS; i++)
                link[i] = i;
            cnt = 0;
            sum = 0;
            for (i = 0; i < held_jobs; i++)
            begin
                s = held_dl[rank[i]];
                root = s;
                while (link[root] != root)
                    root = link[root];
                while (link[s] != root)
                begin
                    nxt = link[s];
                    link[s] = root;
                    s = nxt;
                end
                if (root > 0)
                begin
                    if (cnt < COUNT_SAT)
                        cnt++;
                    sum += held_pr[rank[i]];
                    if (sum > PROFIT_SAT)
                        sum = PROFIT_SAT;
                    link[root] = root - 1;
                end
            end
            res.count = cnt[COUNT_W-1:0];
            res.profit = sum[PROFIT_W-1:0];
            res.overflow = held_ovf;
            awaited_results.insert(awaited_results.size(), res);
            held_jobs = 0;
            held_ovf = 1'b0;
        end
    endtask

    task automatic push_job(input logic [FIELD_W-1:0] dl, input logic [FIELD_W-1:0] pr,
                            input logic last);
        job_beat_t b;
        b.deadline = dl;
        b.profit = pr;
        b.last = last;
        b.calm = 1'b0;
        job_queue.insert(job_queue.size(), b);
    endtask

    task automatic queue_set(input int size, input logic calm);
        int k;
        bit ties;
        job_beat_t b;
        ties = ($urandom_range(0, 3) == 0);
        for (k = 0; k < size; k++)
        begin
            case ($urandom_range(0, 9))
                0: b.deadline = '0;
                1: b.deadline = FIELD_W'($urandom);
                2: b.deadline = FIELD_W'($urandom_range(JOBS - 2, JOBS + 2));
                default: b.deadline = FIELD_W'($urandom_range(1, size));
            endcase
            if (ties)
                b.profit = FIELD_W'($urandom_range(0, 3) * 16'h5555);
            else
            begin
                case ($urandom_range(0, 7))
                    0: b.profit = '0;
                    1: b.profit = '1;
                    default: b.profit = FIELD_W'($urandom);
                endcase
            end
            b.last = (k == size - 1);
            b.calm = calm;
            job_queue.insert(job_queue.size(), b);
        end
    endtask

    function automatic bit drained();
        return job_queue.size() == 0 && !in_valid && awaited_results.size() == 0;
    endfunction

    initial
    begin
        int total;
        int size;
        int pick;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // single-job sets: never runnable, clamped deadline, zero profit
        push_job(16'd0, 16'hFFFF, 1'b1);
        push_job(16'hFFFF, 16'hFFFF, 1'b1);
        push_job(16'd1, 16'd0, 1'b1);
        // equal profits, deadline decides the order
        push_job(16'd1, 16'd7, 1'b0);
        push_job(16'd2, 16'd7, 1'b0);
        push_job(16'd2, 16'd7, 1'b0);
        push_job(16'd1, 16'd9, 1'b0);
        push_job(16'd3, 16'd0, 1'b1);
        // bit patterns and deadlines around the store depth
        push_job(16'h5555, 16'hAAAA, 1'b0);
        push_job(16'hAAAA, 16'h5555, 1'b0);
        push_job(16'd64, 16'd1, 1'b0);
        push_job(16'd65, 16'd1, 1'b0);
        push_job(16'd63, 16'h8000, 1'b1);
        // never-runnable job among contenders for slot one
        push_job(16'd0, 16'd100, 1'b0);
        push_job(16'd1, 16'd50, 1'b0);
        push_job(16'd1, 16'd60, 1'b1);
        push_job(16'd0, 16'd0, 1'b1);

        // hold off until every directed result is back
        while (!drained())
            @(posedge clk);

        total = 0;
        while (total < RANDOM_JOBS)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                size = $urandom_range(JOBS - 1, JOBS + 6);
            else if (pick < 4)
                size = $urandom_range(10, 40);
            else
                size = $urandom_range(1, 8);
            queue_set(size, total >= CALM_FROM);
            total += size;
        end

        while (!drained())
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // idle stretches come and go
    always @(negedge clk)
    begin
        stretch_cnt <= stretch_cnt + 7'd1;
        if (stretch_cnt == '0)
            idle_on <= ($urandom_range(0, 2) != 0);
    end

    // job driver: payload held until the beat is taken
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_took))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (job_queue.size() > 0)
            begin
                if (!calm_now && idle_on && $urandom_range(0, 4) == 0)
                begin
                    gap_left <= $urandom_range(0, 7);
                    in_valid <= 1'b0;
                end
                else
                begin
                    job_deadline <= job_queue[0].deadline;
                    job_profit <= job_queue[0].profit;
                    last_job <= job_queue[0].last;
                    calm_now <= job_queue[0].calm;
                    in_valid <= 1'b1;
                    void'(job_queue.pop_front());
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result stall bursts
    always @(negedge clk)
    begin
        if (!rst_n || calm_now || !idle_on)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 7);
        end
        else
            out_stall <= 1'b0;
    end

    // monitor: predict on job beats, check result beats
    always @(posedge clk)
    begin
        set_result_t want;
        in_took <= rst_n && in_valid && !in_stall;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                take_job(job_deadline, job_profit, last_job);
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch($sformatf("result beat with none awaited: count %0d profit %0d",
                                              scheduled_count, total_profit));
                else
                begin
                    want = awaited_results.pop_front();
                    if (scheduled_count !== want.count)
                        report_mismatch($sformatf("scheduled_count %0d, want %0d",
                                                  scheduled_count, want.count));
                    if (total_profit !== want.profit)
                        report_mismatch($sformatf("total_profit %0d, want %0d",
                                                  total_profit, want.profit));
                    if (set_overflow !== want.overflow)
                        report_mismatch($sformatf("set_overflow %0b, want %0b",
                                                  set_overflow, want.overflow));
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= HANG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

endmodule

// ===== filelist.f =====
rtl/djss_pkg.sv
rtl/djss_ram.sv
rtl/deadline_job_slot_scheduler.sv
test/testbench.sv
